// File: hdl/ptp_pkg.sv
// Package: request/response types, command codes and defaults for the periodic timer pool.
`default_nettype none

package ptp_pkg;

    // Default sizing
    localparam int NUM_TIMERS_DEF    = 8;
    localparam int INTERVAL_BITS_DEF = 16;

    // Command codes
    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_SET_IVL = 3'd1;
    localparam logic [2:0] CMD_SET_REP = 3'd2;
    localparam logic [2:0] CMD_START   = 3'd3;
    localparam logic [2:0] CMD_STOP    = 3'd4;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    // Request payload
    typedef struct packed {
        logic [2:0]  command;
        logic [2:0]  timer_index;
        logic [15:0] value;
    } t_req;

    // Response payload
    typedef struct packed {
        logic [7:0]  fired_mask;
        logic [15:0] ticks_to_next;
    } t_rsp;

endpackage

`default_nettype wire

// File: hdl/periodic_timer_pool_core.sv
// Periodic timer pool: one request is applied, then every timer is visited once per request.
// The response is registered on the last timer of the scan and is valid in S_DONE.
// Requests wait until the last response is accepted; the single sweep over the interval
//   and remaining-count memories, one timer per cycle, paces the requests.
// Reset (synchronous, active low): all timers stopped, disarmed, one-shot, interval and
//   remaining count read as zero; the block is idle and ready.
`default_nettype none

module periodic_timer_pool_core #(
    parameter int NUM_TIMERS    = ptp_pkg::NUM_TIMERS_DEF,
    parameter int INTERVAL_BITS = ptp_pkg::INTERVAL_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_req_valid,
    output logic               o_req_ready,
    input  wire ptp_pkg::t_req i_req,
    output logic               o_rsp_valid,
    input  wire logic          i_rsp_ready,
    output ptp_pkg::t_rsp      o_rsp
);
    import ptp_pkg::*;

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int VB = INTERVAL_BITS;

    // Sequencer
    t_state r_state, n_state;
    logic   accept;
    logic   scan_en;
    logic   last;

    // Latched request
    logic [2:0]    r_cmd;
    logic          r_cidx_ok;
    logic [IW-1:0] r_caddr;

    // Request decode
    logic [6:0]    req_idx7;
    logic          req_idx_ok;
    logic [IW-1:0] req_addr;
    logic [31:0]   req_val32;

    // Timer flags and memory valid bits
    logic [NUM_TIMERS-1:0] r_repeat, r_running, r_armed;
    logic [NUM_TIMERS-1:0] r_iv_vld, r_rem_vld;

    // Interval and remaining-count memories
    logic [VB-1:0] r_iv_mem  [NUM_TIMERS];
    logic [VB-1:0] r_rem_mem [NUM_TIMERS];
    logic [VB-1:0] r_iv_q, r_rem_q;
    logic [IW-1:0] rd_addr;
    logic          iv_we;
    logic          rem_we;
    logic [VB-1:0] rem_wdata;

    // Scan datapath
    logic [IW-1:0] r_idx;
    logic [6:0]    idx7;
    logic [VB-1:0] iv_cur, rem_cur, rem_new, dist_ticks;
    logic          active, arm_new, fire, active_new;
    logic [VB-1:0] r_best, n_best;
    logic          r_any, n_any;
    logic [7:0]    r_fired, n_fired;
    logic [31:0]   best32;
    t_rsp          r_rsp;

    // Request decode
    assign req_idx7   = 7'(i_req.timer_index);
    assign req_idx_ok = (req_idx7 < 7'(NUM_TIMERS));
    assign req_addr   = req_idx7[IW-1:0];
    assign req_val32  = 32'(i_req.value);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_req_valid) n_state = S_SCAN;
            S_SCAN: if (last) n_state = S_DONE;
            S_DONE: if (i_rsp_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_req_ready = (r_state == S_IDLE);
        o_rsp_valid = (r_state == S_DONE);
        scan_en     = (r_state == S_SCAN);
    end

    assign accept = i_req_valid && o_req_ready;
    assign last   = (r_idx == IW'(NUM_TIMERS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Read address: first timer while idle, next timer while scanning
    always_comb begin
        if (scan_en && !last) begin
            rd_addr = r_idx + 1'b1;
        end else begin
            rd_addr = '0;
        end
    end

    // Interval memory: written by set-interval requests
    assign iv_we = accept && req_idx_ok && (i_req.command == CMD_SET_IVL);

    always_ff @(posedge i_clk) begin
        if (iv_we) begin
            r_iv_mem[req_addr] <= req_val32[VB-1:0];
        end
        r_iv_q <= r_iv_mem[rd_addr];
    end

    // Remaining-count memory: written during the scan
    always_ff @(posedge i_clk) begin
        if (rem_we) begin
            r_rem_mem[r_idx] <= rem_wdata;
        end
        r_rem_q <= r_rem_mem[rd_addr];
    end

    // Per-timer update for the timer under scan
    assign idx7    = 7'(r_idx);
    assign iv_cur  = r_iv_vld[r_idx]  ? r_iv_q  : '0;
    assign rem_cur = r_rem_vld[r_idx] ? r_rem_q : '0;
    assign active  = r_running[r_idx] && r_armed[r_idx];

    always_comb begin
        rem_new = rem_cur;
        arm_new = r_armed[r_idx];
        fire    = 1'b0;
        rem_we  = 1'b0;
        if (r_cmd == CMD_TICK) begin
            if (active) begin
                rem_we = 1'b1;
                if (rem_cur <= VB'(1)) begin
                    fire = 1'b1;
                    if (r_repeat[r_idx]) begin
                        rem_new = iv_cur;
                    end else begin
                        arm_new = 1'b0;
                        rem_we  = 1'b0;
                    end
                end else begin
                    rem_new = rem_cur - 1'b1;
                end
            end
        end else if (r_cmd == CMD_START && r_cidx_ok && r_idx == r_caddr) begin
            rem_new = iv_cur;
            rem_we  = 1'b1;
        end
        rem_we    = rem_we && scan_en;
        rem_wdata = rem_new;
    end

    // Running minimum of the pending distance, and fired mask
    assign active_new = r_running[r_idx] && arm_new;
    assign dist_ticks = (rem_new == '0) ? VB'(1) : rem_new;

    always_comb begin
        n_best  = r_best;
        n_any   = r_any;
        n_fired = r_fired;
        if (active_new && (!r_any || dist_ticks < r_best)) begin
            n_best = dist_ticks;
            n_any  = 1'b1;
        end
        if (fire && idx7 < 7'd8) begin
            n_fired[idx7[2:0]] = 1'b1;
        end
    end

    assign best32 = 32'(n_best);

    // Flags, valid bits and scan bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat  <= '0;
            r_running <= '0;
            r_armed   <= '0;
            r_iv_vld  <= '0;
            r_rem_vld <= '0;
            r_idx     <= '0;
        end else if (accept) begin
            r_idx <= '0;
            if (req_idx_ok) begin
                unique case (i_req.command)
                    CMD_SET_IVL: r_iv_vld[req_addr] <= 1'b1;
                    CMD_SET_REP: r_repeat[req_addr] <= i_req.value[0];
                    CMD_START: begin
                        r_running[req_addr] <= 1'b1;
                        r_armed[req_addr]   <= 1'b1;
                    end
                    CMD_STOP:  r_running[req_addr] <= 1'b0;
                    default: ;
                endcase
            end
        end else if (scan_en) begin
            r_armed[r_idx] <= arm_new;
            if (rem_we) begin
                r_rem_vld[r_idx] <= 1'b1;
            end
            if (!last) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // Latched request and accumulators
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd     <= i_req.command;
            r_cidx_ok <= req_idx_ok;
            r_caddr   <= req_addr;
            r_best    <= '0;
            r_any     <= 1'b0;
            r_fired   <= '0;
        end else if (scan_en) begin
            r_best  <= n_best;
            r_any   <= n_any;
            r_fired <= n_fired;
        end
    end

    // Response register, loaded on the last timer of the scan
    always_ff @(posedge i_clk) begin
        if (scan_en && last) begin
            r_rsp.fired_mask <= n_fired;
            if (!n_any) begin
                r_rsp.ticks_to_next <= '0;
            end else if (best32 > 32'h0000_FFFF) begin
                r_rsp.ticks_to_next <= 16'hFFFF;
            end else begin
                r_rsp.ticks_to_next <= best32[15:0];
            end
        end
    end

    assign o_rsp = r_rsp;

endmodule

`default_nettype wire

// File: hdl/ptp_checker.sv
// Port-level checker for the periodic timer pool, bound to the top level.
`default_nettype none

module ptp_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_req_valid,
    input wire logic          o_req_ready,
    input wire ptp_pkg::t_req i_req,
    input wire logic          o_rsp_valid,
    input wire logic          i_rsp_ready,
    input wire ptp_pkg::t_rsp o_rsp
);
    import ptp_pkg::*;

    // A stalled response holds its payload
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("response dropped or changed while stalled");

    // After an accepted request the block is busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !o_req_ready && !o_rsp_valid)
        else $error("request taken while a request is in progress");

    // Only one request in flight: no new request while a response waits
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> !o_req_ready)
        else $error("ready while a response is pending");

    // Reset leaves no response pending
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp_valid && o_req_ready)
        else $error("response or busy state after reset");

endmodule

bind periodic_timer_pool_core ptp_checker u_ptp_checker (.*);

`default_nettype wire
